// File: design/assert_macros.svh
// assertion macros used by the deframer unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property checked at every clock edge outside reset
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition followed in the next cycle by another
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`else

`define ASSERT_AT(lbl, prop, msg)
`define ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

// File: design/lppd_pkg.sv
// types and constants of the packet deframer
package lppd_pkg;

  localparam int MaxPayload  = 512;
  localparam int HeaderBytes = 8;
  localparam int CrcBytes    = 4;
  localparam int CountW      = $clog2(MaxPayload + 1);
  localparam int IdxW        = 9;

  localparam logic [7:0] StartMarkerRst = 8'h02;

  typedef enum logic [2:0] {
    KindHeader  = 3'd0,
    KindPayload = 3'd1,
    KindCrc     = 3'd2,
    KindDone    = 3'd3,
    KindLenErr  = 3'd4
  } kind_e;

endpackage

// File: design/length_prefixed_packet_deframer_unit.sv
// length-prefixed packet deframer: one received byte in, at most one result out
//
// Takes one byte per beat. Idle bytes are skipped until the start marker
// (register, reset 0x02). Eight big-endian header bytes follow (32-bit total
// size, 16-bit packet id, 16-bit payload length), then the payload bytes, each
// given out with its index, then a 4-byte big-endian CRC word, then one trigger
// byte that closes the packet. A payload length above 512 gives a length-error
// result and the block drops back to idle; a zero length goes straight to the
// CRC. An input register and a result register surround a single pass of
// state update logic, so one beat can be taken every cycle unless the output
// stalls; both the input and the result are registered. Results carry the
// last decoded header fields. Write the start marker only while idle.
`include "assert_macros.svh"

module length_prefixed_packet_deframer_unit
  import lppd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic [8:0]  byte_index_o,
  output logic [31:0] frame_size_o,
  output logic [15:0] frame_tag_o,
  output logic [15:0] body_length_o,
  output logic [31:0] crc_word_o
);

  typedef enum logic [2:0] {
    PhIdle,
    PhHeader,
    PhData,
    PhCrc,
    PhExec
  } phase_e;

  logic [7:0]        start_marker_q;
  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              advance;

  phase_e            phase_q, phase_d;
  logic [CountW-1:0] field_count_q, field_count_d, cnt_inc;
  logic [63:0]       hdr_q, hdr_d, hdr_shift;
  logic [31:0]       crc_q, crc_d, crc_shift;

  logic              emit;
  kind_e             kind_d;
  logic [7:0]        data_d;
  logic [IdxW-1:0]   idx_d;
  logic [31:0]       crc_out_d;

  logic              out_valid_q;
  kind_e             kind_q;
  logic [7:0]        data_q;
  logic [IdxW-1:0]   idx_q;
  logic [63:0]       hdr_out_q;
  logic [31:0]       crc_out_q;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  always_comb begin
    phase_d       = phase_q;
    field_count_d = field_count_q;
    hdr_d         = hdr_q;
    crc_d         = crc_q;
    emit          = 1'b0;
    kind_d        = KindHeader;
    data_d        = 8'd0;
    idx_d         = '0;
    crc_out_d     = 32'd0;
    cnt_inc       = field_count_q + CountW'(1);
    hdr_shift     = {hdr_q[55:0], in_byte_q};
    crc_shift     = {crc_q[23:0], in_byte_q};
    case (phase_q)
      PhIdle: begin
        if (in_byte_q == start_marker_q) begin
          field_count_d = '0;
          phase_d       = PhHeader;
        end
      end
      PhHeader: begin
        hdr_d = hdr_shift;
        if (cnt_inc == CountW'(HeaderBytes)) begin
          field_count_d = '0;
          emit          = 1'b1;
          if (hdr_shift[15:0] > 16'(MaxPayload)) begin
            phase_d = PhIdle;
            kind_d  = KindLenErr;
          end else if (hdr_shift[15:0] == 16'd0) begin
            phase_d = PhCrc;
          end else begin
            phase_d = PhData;
          end
        end else begin
          field_count_d = cnt_inc;
        end
      end
      PhData: begin
        emit   = 1'b1;
        kind_d = KindPayload;
        data_d = in_byte_q;
        idx_d  = field_count_q[IdxW-1:0];
        if (16'(cnt_inc) >= hdr_q[15:0]) begin
          field_count_d = '0;
          phase_d       = PhCrc;
        end else begin
          field_count_d = cnt_inc;
        end
      end
      PhCrc: begin
        crc_d = crc_shift;
        if (cnt_inc == CountW'(CrcBytes)) begin
          field_count_d = '0;
          phase_d       = PhExec;
          emit          = 1'b1;
          kind_d        = KindCrc;
          crc_out_d     = crc_shift;
        end else begin
          field_count_d = cnt_inc;
        end
      end
      PhExec: begin
        phase_d       = PhIdle;
        field_count_d = '0;
        emit          = 1'b1;
        kind_d        = KindDone;
        crc_out_d     = crc_q;
      end
      default: begin
        phase_d       = PhIdle;
        field_count_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q <= StartMarkerRst;
      in_valid_q     <= 1'b0;
      in_byte_q      <= 8'd0;
      phase_q        <= PhIdle;
      field_count_q  <= '0;
      hdr_q          <= 64'd0;
      crc_q          <= 32'd0;
      out_valid_q    <= 1'b0;
      kind_q         <= KindHeader;
      data_q         <= 8'd0;
      idx_q          <= '0;
      hdr_out_q      <= 64'd0;
      crc_out_q      <= 32'd0;
    end else begin
      if (cfg_we_i) begin
        start_marker_q <= cfg_wdata_i;
      end
      // input register
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
        if (in_valid_i) begin
          in_byte_q <= rx_byte_i;
        end
      end
      if (advance) begin
        phase_q       <= phase_d;
        field_count_q <= field_count_d;
        hdr_q         <= hdr_d;
        crc_q         <= crc_d;
        out_valid_q   <= emit;
        if (emit) begin
          kind_q    <= kind_d;
          data_q    <= data_d;
          idx_q     <= idx_d;
          hdr_out_q <= hdr_d;
          crc_out_q <= crc_out_d;
        end
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign data_byte_o   = data_q;
  assign byte_index_o  = idx_q;
  assign frame_size_o  = hdr_out_q[63:32];
  assign frame_tag_o   = hdr_out_q[31:16];
  assign body_length_o = hdr_out_q[15:0];
  assign crc_word_o    = crc_out_q;

  `ASSERT_AT(a_stall_needs_beat, in_stall_o |-> (in_valid_q && out_valid_q), "stall without held beat")
  `ASSERT_AT(a_data_cnt_in_range, (phase_q == PhData) |-> (16'(field_count_q) < hdr_q[15:0]), "payload count past length")
  `ASSERT_AT(a_index_in_range, (out_valid_o && kind_o == KindPayload) |-> (16'(byte_index_o) < body_length_o), "payload index past length")
  `ASSERT_AT(a_data_zero, (out_valid_o && kind_o != KindPayload) |-> (data_byte_o == 8'd0), "data byte set outside payload")
  `ASSERT_NEXT(a_lenerr_to_idle, (advance && emit && kind_d == KindLenErr), (phase_q == PhIdle), "length error did not return to idle")

endmodule
